FILE: design/lowest_common_ancestor_engine_macros.svh
// ----------------------------------------------------------------------------
// lowest common ancestor engine assertion macros
// shared concurrent assertion forms, clocked and disabled by the caller
// ----------------------------------------------------------------------------
`ifndef LOWEST_COMMON_ANCESTOR_ENGINE_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_ENGINE_MACROS_SVH

// condition must hold in the same cycle
`define LCA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the next cycle
`define LCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition must never hold
`define LCA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: design/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// shared types, codes and helpers of the lowest common ancestor engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 10;
   localparam int DIST_W  = 11;
   localparam int LOG_W   = 4;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

   localparam logic [1:0] KIND_ROOT  = 2'd0;
   localparam logic [1:0] KIND_CHILD = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_DUP     = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } jump_entry_type;

   typedef struct packed {
      logic               present;
      logic [DEPTH_W-1:0] depth;
   } node_rec_type;

   function automatic int lvl_width(input int levels);
      return (levels > 1) ? $clog2(levels) : 1;
   endfunction

   function automatic logic [LOG_W-1:0] floor_log2(input logic [DEPTH_W-1:0] v);
      logic [LOG_W-1:0] r;
      r = '0;
      for (int i = 0; i < DEPTH_W; i++) begin
         if (v[i]) begin
            r = LOG_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/lca_node_store.sv
// ----------------------------------------------------------------------------
// lca_node_store
// presence and depth memory, swept clear after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lca_node_store import lca_pkg::*; #(
   parameter int NODES = 1024,
   parameter int AW    = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire node_rec_type wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output node_rec_type      rd_data,
   output logic              clr_busy
);

   node_rec_type mem [NODES];
   node_rec_type rd_data_ff;

   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] clr_cnt_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(NODES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

FILE: design/lca_jump_store.sv
// ----------------------------------------------------------------------------
// lca_jump_store
// binary lifting table, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lca_jump_store import lca_pkg::*; #(
   parameter int JAW    = 14
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [JAW-1:0] wr_addr,
   input  wire jump_entry_type wr_data,
   input  wire logic [JAW-1:0] rd_addr_a,
   input  wire logic [JAW-1:0] rd_addr_b,
   output jump_entry_type     rd_data_a,
   output jump_entry_type     rd_data_b
);

   localparam int DEPTH = 1 << JAW;

   jump_entry_type mem [DEPTH];
   jump_entry_type rd_a_ff;
   jump_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: design/lowest_common_ancestor_engine.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine
// rooted forest kept as a binary lifting table; adds nodes, answers
// lowest common ancestor and distance queries
//
//   channel  dir  contents
//   req      in   tuser: kind; tdata: node_a, node_b
//   rsp      out  tdata: ancestor, distance, status
//
// one item at a time, sequenced over the node memory and the jump table,
// each access a registered read followed by a decision state. a root add
// clears every level of its jump entry; a child add fills the levels one
// by one; a query lifts the deeper node, compares down the levels and
// climbs, skipping the compare and climb when the lifted nodes already meet.
// the next request is taken once the result has moved to the output
// register. after reset the node memory is swept clear; req_tready
// stays low meanwhile. a held result does not block the next request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lowest_common_ancestor_engine_macros.svh"

module lowest_common_ancestor_engine import lca_pkg::*; #(
   parameter int NODES      = 1024,
   parameter int LOG_LEVELS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // node_a, node_b, zero pad
   input  wire logic [1:0]  req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // ancestor, distance, status, zero pad
);

   localparam int AW  = $clog2(NODES);
   localparam int LW  = lvl_width(LOG_LEVELS);
   localparam int JAW = AW + LW;

   localparam logic [16:0]   NODES_V  = 17'(NODES);
   localparam logic [LW-1:0] LVL_LAST = LW'(LOG_LEVELS - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_RD_A     = 5'd1;
   localparam logic [4:0] S_RD_B     = 5'd2;
   localparam logic [4:0] S_CHK      = 5'd3;
   localparam logic [4:0] S_ROOT_WR  = 5'd4;
   localparam logic [4:0] S_FILL_RD  = 5'd5;
   localparam logic [4:0] S_FILL_WT  = 5'd6;
   localparam logic [4:0] S_LIFT_RD  = 5'd7;
   localparam logic [4:0] S_LIFT_WT  = 5'd8;
   localparam logic [4:0] S_CMP_RD   = 5'd9;
   localparam logic [4:0] S_CMP_WT   = 5'd10;
   localparam logic [4:0] S_CLIMB_RD = 5'd11;
   localparam logic [4:0] S_CLIMB_WT = 5'd12;
   localparam logic [4:0] S_DEP_RD   = 5'd13;
   localparam logic [4:0] S_DEP_WT   = 5'd14;
   localparam logic [4:0] S_DONE     = 5'd15;

   function automatic logic in_range(input logic [NODE_W-1:0] n);
      return {7'd0, n} < NODES_V;
   endfunction

   function automatic logic [JAW-1:0] jaddr(input logic [NODE_W-1:0] n,
                                            input logic [LW-1:0] l);
      return {AW'(n), l};
   endfunction

   // memory ports
   logic           nm_wr_en;
   logic [AW-1:0]  nm_wr_addr;
   node_rec_type   nm_wr_data;
   logic [AW-1:0]  nm_rd_addr;
   node_rec_type   nm_q;
   logic           clr_busy;

   logic           jm_wr_en;
   logic [JAW-1:0] jm_wr_addr;
   jump_entry_type jm_wr_data;
   logic [JAW-1:0] jm_rd_addr_a;
   logic [JAW-1:0] jm_rd_addr_b;
   jump_entry_type jm_qa;
   jump_entry_type jm_qb;

   // sequencer state
   logic [4:0]         state_ff,  state_in;
   logic [1:0]         kind_ff,   kind_in;
   logic [NODE_W-1:0]  a_ff,      a_in;
   logic [NODE_W-1:0]  b_ff,      b_in;
   logic [NODE_W-1:0]  x_ff,      x_in;
   logic [NODE_W-1:0]  y_ff,      y_in;
   logic [NODE_W-1:0]  lca_ff,    lca_in;
   logic [DEPTH_W-1:0] da_ff,     da_in;
   logic [DEPTH_W-1:0] db_ff,     db_in;
   logic [DEPTH_W-1:0] diff_ff,   diff_in;
   logic [LW-1:0]      lvl_ff,    lvl_in;
   jump_entry_type     cur_ff,    cur_in;
   logic [NODE_W-1:0]  res_anc_ff,  res_anc_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic [1:0]         res_st_ff,   res_st_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_anc_ff,   rsp_anc_in;
   logic [DIST_W-1:0]  rsp_dist_ff,  rsp_dist_in;
   logic [1:0]         rsp_st_ff,    rsp_st_in;

   logic [LOG_W-1:0]   diff_log;
   logic [LW-1:0]      lift_lvl;
   logic [DEPTH_W-1:0] child_depth;
   logic               req_beat;

   lca_node_store #(
      .NODES (NODES),
      .AW    (AW)
   ) u_node_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (nm_wr_en),
      .wr_addr  (nm_wr_addr),
      .wr_data  (nm_wr_data),
      .rd_addr  (nm_rd_addr),
      .rd_data  (nm_q),
      .clr_busy (clr_busy)
   );

   lca_jump_store #(
      .JAW   (JAW)
   ) u_jump_store (
      .clock     (clock),
      .wr_en     (jm_wr_en),
      .wr_addr   (jm_wr_addr),
      .wr_data   (jm_wr_data),
      .rd_addr_a (jm_rd_addr_a),
      .rd_addr_b (jm_rd_addr_b),
      .rd_data_a (jm_qa),
      .rd_data_b (jm_qb)
   );

   assign req_tready  = (state_ff == S_IDLE) && !clr_busy;
   assign req_beat    = req_tvalid && req_tready;
   assign diff_log    = floor_log2(diff_ff);
   assign lift_lvl    = ({1'b0, diff_log} > 5'(LOG_LEVELS - 1)) ? LVL_LAST : LW'(diff_log);
   assign child_depth = (nm_q.depth == DEPTH_MAX) ? DEPTH_MAX : nm_q.depth + DEPTH_W'(1);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      lca_in      = lca_ff;
      da_in       = da_ff;
      db_in       = db_ff;
      diff_in     = diff_ff;
      lvl_in      = lvl_ff;
      cur_in      = cur_ff;
      res_anc_in  = res_anc_ff;
      res_dist_in = res_dist_ff;
      res_st_in   = res_st_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_anc_in   = rsp_anc_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_st_in    = rsp_st_ff;

      nm_wr_en     = 1'b0;
      nm_wr_addr   = AW'(a_ff);
      nm_wr_data   = '0;
      nm_rd_addr   = AW'(a_ff);
      jm_wr_en     = 1'b0;
      jm_wr_addr   = jaddr(a_ff, lvl_ff);
      jm_wr_data   = '0;
      jm_rd_addr_a = jaddr(x_ff, lvl_ff);
      jm_rd_addr_b = jaddr(y_ff, lvl_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               kind_in     = req_tuser;
               a_in        = req_tdata[9:0];
               b_in        = req_tdata[19:10];
               res_anc_in  = '0;
               res_dist_in = '0;
               res_st_in   = ST_OK;
               if (req_tuser == KIND_ROOT || req_tuser == KIND_CHILD ||
                   req_tuser == KIND_QUERY) begin
                  state_in = S_RD_A;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD_A: begin
            if (!in_range(a_ff)) begin
               res_st_in = ST_MISSING;
               state_in  = S_DONE;
            end else begin
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            da_in      = nm_q.depth;
            nm_rd_addr = AW'(b_ff);
            case (kind_ff)
               KIND_ROOT: begin
                  if (nm_q.present) begin
                     res_st_in = ST_DUP;
                     state_in  = S_DONE;
                  end else begin
                     nm_wr_en   = 1'b1;
                     nm_wr_data = '{present: 1'b1, depth: '0};
                     lvl_in     = '0;
                     state_in   = S_ROOT_WR;
                  end
               end
               KIND_CHILD: begin
                  if (nm_q.present) begin
                     res_st_in = ST_DUP;
                     state_in  = S_DONE;
                  end else if (!in_range(b_ff)) begin
                     res_st_in = ST_MISSING;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_CHK;
                  end
               end
               KIND_QUERY: begin
                  if (!nm_q.present || !in_range(b_ff)) begin
                     res_st_in = ST_MISSING;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_CHK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CHK: begin
            db_in = nm_q.depth;
            if (!nm_q.present) begin
               res_st_in = ST_MISSING;
               state_in  = S_DONE;
            end else if (kind_ff == KIND_CHILD) begin
               nm_wr_en   = 1'b1;
               nm_wr_data = '{present: 1'b1, depth: child_depth};
               jm_wr_en   = 1'b1;
               jm_wr_addr = jaddr(a_ff, '0);
               jm_wr_data = '{valid: 1'b1, node: b_ff};
               cur_in     = '{valid: 1'b1, node: b_ff};
               lvl_in     = LW'(1);
               state_in   = (LOG_LEVELS == 1) ? S_DONE : S_FILL_RD;
            end else begin
               if (da_ff > nm_q.depth) begin
                  x_in    = b_ff;
                  y_in    = a_ff;
                  diff_in = da_ff - nm_q.depth;
               end else begin
                  x_in    = a_ff;
                  y_in    = b_ff;
                  diff_in = nm_q.depth - da_ff;
               end
               state_in = S_LIFT_RD;
            end
         end
         S_ROOT_WR: begin
            jm_wr_en   = 1'b1;
            jm_wr_data = '0;
            if (lvl_ff == LVL_LAST) begin
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff + LW'(1);
            end
         end
         S_FILL_RD: begin
            if (cur_ff.valid && in_range(cur_ff.node)) begin
               jm_rd_addr_a = jaddr(cur_ff.node, lvl_ff - LW'(1));
               state_in     = S_FILL_WT;
            end else begin
               jm_wr_en   = 1'b1;
               jm_wr_data = '0;
               cur_in     = '0;
               if (lvl_ff == LVL_LAST) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in = lvl_ff + LW'(1);
               end
            end
         end
         S_FILL_WT: begin
            jm_wr_en   = 1'b1;
            jm_wr_data = jm_qa;
            cur_in     = jm_qa;
            if (lvl_ff == LVL_LAST) begin
               state_in = S_DONE;
            end else begin
               lvl_in   = lvl_ff + LW'(1);
               state_in = S_FILL_RD;
            end
         end
         S_LIFT_RD: begin
            if (diff_ff == '0) begin
               if (x_ff == y_ff) begin
                  lca_in   = x_ff;
                  state_in = S_DEP_RD;
               end else begin
                  lvl_in   = LVL_LAST;
                  state_in = S_CMP_RD;
               end
            end else begin
               jm_rd_addr_a = jaddr(y_ff, lift_lvl);
               lvl_in       = lift_lvl;
               state_in     = S_LIFT_WT;
            end
         end
         S_LIFT_WT: begin
            if (!jm_qa.valid || !in_range(jm_qa.node)) begin
               res_st_in = ST_MISSING;
               state_in  = S_DONE;
            end else begin
               y_in     = jm_qa.node;
               diff_in  = diff_ff - (DEPTH_W'(1) << lvl_ff);
               state_in = S_LIFT_RD;
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_WT;
         end
         S_CMP_WT: begin
            if (jm_qa.valid && jm_qb.valid && (jm_qa != jm_qb) &&
                in_range(jm_qa.node) && in_range(jm_qb.node)) begin
               x_in = jm_qa.node;
               y_in = jm_qb.node;
            end
            if (lvl_ff == '0) begin
               state_in = S_CLIMB_RD;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = S_CMP_RD;
            end
         end
         S_CLIMB_RD: begin
            jm_rd_addr_a = jaddr(x_ff, '0);
            jm_rd_addr_b = jaddr(y_ff, '0);
            state_in     = S_CLIMB_WT;
         end
         S_CLIMB_WT: begin
            if (!jm_qa.valid || !jm_qb.valid ||
                !in_range(jm_qa.node) || !in_range(jm_qb.node)) begin
               res_st_in = ST_MISSING;
               state_in  = S_DONE;
            end else if (jm_qa == jm_qb) begin
               lca_in   = jm_qa.node;
               state_in = S_DEP_RD;
            end else begin
               x_in     = jm_qa.node;
               y_in     = jm_qb.node;
               state_in = S_CLIMB_RD;
            end
         end
         S_DEP_RD: begin
            nm_rd_addr = AW'(lca_ff);
            state_in   = S_DEP_WT;
         end
         S_DEP_WT: begin
            res_anc_in  = lca_ff;
            res_dist_in = ({1'b0, da_ff} + {1'b0, db_ff}) - {nm_q.depth, 1'b0};
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = res_anc_ff;
               rsp_dist_in  = res_dist_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      lca_ff      <= lca_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      diff_ff     <= diff_in;
      lvl_ff      <= lvl_in;
      cur_ff      <= cur_in;
      res_anc_ff  <= res_anc_in;
      res_dist_ff <= res_dist_in;
      res_st_ff   <= res_st_in;
      rsp_anc_ff  <= rsp_anc_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_st_ff, rsp_dist_ff, rsp_anc_ff};

   `LCA_ASSERT_NEVER(a_no_write_in_clear, clock, reset, clr_busy && nm_wr_en, "node write during clear sweep")
   `LCA_ASSERT_NEXT(a_beat_starts_item, clock, reset, req_beat, state_ff == S_RD_A || state_ff == S_DONE, "request beat did not start an item")
   `LCA_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_valid_ff && (rsp_st_ff != ST_OK), (rsp_anc_ff == '0) && (rsp_dist_ff == '0), "error result carries data")
   `LCA_ASSERT_IMPLY(a_fill_level, clock, reset, state_ff == S_FILL_RD || state_ff == S_FILL_WT, lvl_ff != '0, "fill at level zero")

endmodule

`default_nettype wire

FILE: tb/sv/lca_answer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_answer_checker
// watches the request and response channels of the lowest common ancestor
// engine, keeps its own copy of the forest and the lifting table, works
// out the answer of every accepted request and compares each response
// beat, field by field, against the oldest answer still due
// ----------------------------------------------------------------------------

module lca_answer_checker import lca_pkg::*; #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // node_a, node_b, zero pad
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // ancestor, distance, status, zero pad
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count
);

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [DIST_W-1:0] distance;
      logic [1:0]        status;
   } answer_type;

   bit                 node_present [NODES];
   logic [DEPTH_W-1:0] node_level   [NODES];
   jump_entry_type     lift_tab     [NODES][LEVELS];
   answer_type         answers_due  [$];
   int                 misses  = 0;
   int                 checked = 0;

   function automatic answer_type next_answer(input logic [1:0] kind,
                                              input logic [NODE_W-1:0] a,
                                              input logic [NODE_W-1:0] b);
      answer_type        ans;
      logic [NODE_W-1:0] x;
      logic [NODE_W-1:0] y;
      logic [NODE_W-1:0] t;
      jump_entry_type    ex;
      jump_entry_type    ey;
      jump_entry_type    prev;
      int                diff;
      int                lv;
      bit                fail;
      bit                done;
      ans = '0;
      case (kind)
         KIND_ROOT: begin
            if (node_present[a]) begin
               ans.status = ST_DUP;
            end else begin
               node_present[a] = 1'b1;
               node_level[a]   = '0;
               for (int i = 0; i < LEVELS; i++) lift_tab[a][i] = '0;
            end
         end
         KIND_CHILD: begin
            if (node_present[a]) begin
               ans.status = ST_DUP;
            end else if (!node_present[b]) begin
               ans.status = ST_MISSING;
            end else begin
               node_present[a] = 1'b1;
               node_level[a]   = (node_level[b] == DEPTH_MAX) ? DEPTH_MAX
                                                              : node_level[b] + DEPTH_W'(1);
               lift_tab[a][0].valid = 1'b1;
               lift_tab[a][0].node  = b;
               for (int i = 1; i < LEVELS; i++) begin
                  prev = lift_tab[a][i-1];
                  lift_tab[a][i] = prev.valid ? lift_tab[prev.node][i-1] : '0;
               end
            end
         end
         KIND_QUERY: begin
            if (!node_present[a] || !node_present[b]) begin
               ans.status = ST_MISSING;
            end else begin
               x = a;
               y = b;
               if (node_level[x] > node_level[y]) begin
                  t = x;
                  x = y;
                  y = t;
               end
               diff = int'(node_level[y]) - int'(node_level[x]);
               fail = 1'b0;
               // bring the deeper node up to the same level
               while (diff > 0 && !fail) begin
                  lv = 0;
                  for (int k = 1; k < 32; k++) if ((diff >> k) != 0) lv = k;
                  if (lv > LEVELS - 1) lv = LEVELS - 1;
                  ex = lift_tab[y][lv];
                  if (!ex.valid) begin
                     fail = 1'b1;
                  end else begin
                     y = ex.node;
                     diff -= (1 << lv);
                  end
               end
               if (!fail && x != y) begin
                  for (int i = LEVELS - 1; i >= 0; i--) begin
                     ex = lift_tab[x][i];
                     ey = lift_tab[y][i];
                     if (ex.valid && ey.valid && ex != ey) begin
                        x = ex.node;
                        y = ey.node;
                     end
                  end
                  done = 1'b0;
                  while (!fail && !done) begin
                     ex = lift_tab[x][0];
                     ey = lift_tab[y][0];
                     if (!ex.valid || !ey.valid) begin
                        fail = 1'b1;
                     end else if (ex == ey) begin
                        done = 1'b1;
                        x    = ex.node;
                     end else begin
                        x = ex.node;
                        y = ey.node;
                     end
                  end
               end
               if (fail) begin
                  ans.status = ST_MISSING;
               end else begin
                  ans.ancestor = x;
                  ans.distance = DIST_W'(int'(node_level[a]) + int'(node_level[b])
                                         - 2 * int'(node_level[x]));
               end
            end
         end
         default: ans = '0;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      answer_type got;
      if (reset) begin
         for (int n = 0; n < NODES; n++) node_present[n] = 1'b0;
         answers_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            answers_due = {answers_due,
                           next_answer(req_tuser, req_tdata[9:0], req_tdata[19:10])};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ancestor = rsp_tdata[9:0];
            got.distance = rsp_tdata[20:10];
            got.status   = rsp_tdata[22:21];
            if (answers_due.size() == 0) begin
               $error("response beat with no request waiting: %h", rsp_tdata);
               misses++;
            end else begin
               want = answers_due.pop_front();
               checked++;
               if (got.ancestor !== want.ancestor) begin
                  $error("ancestor: expected %0d, got %0d", want.ancestor, got.ancestor);
                  misses++;
               end
               if (got.distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, got.distance);
                  misses++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  misses++;
               end
            end
         end
      end
      mismatch_count <= misses;
      pending_count  <= answers_due.size();
      checked_count  <= checked;
   end

endmodule

FILE: tb/sv/lowest_common_ancestor_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine_test
// drives the engine with a short directed sequence and then random forests
// of roots, children and chains, mixed with queries and malformed beats,
// under three idling patterns; the checker beside the block predicts and
// compares every response
// ----------------------------------------------------------------------------

module lowest_common_ancestor_engine_test;
   import lca_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         LIMIT       = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // node_a, node_b, zero pad
   logic [1:0]  req_tuser  = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // ancestor, distance, status, zero pad

   int mismatch_count;
   int pending_count;
   int checked_count;

   int send_idle  = 0;
   int recv_idle  = 0;
   int cycles     = 0;
   int beats_sent = 0;
   int adds_sent  = 0;
   int asks_sent  = 0;
   int odd_sent   = 0;
   int last_node  = -1;

   bit node_used [1024];
   int members   [$];

   lowest_common_ancestor_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lca_answer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int free_node();
      int n;
      do n = $urandom_range(1023); while (node_used[n]);
      return n;
   endfunction

   task automatic send_beat(input logic [1:0] kind, input int a, input int b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, NODE_W'(b), NODE_W'(a)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (kind == KIND_QUERY) asks_sent++;
      else if (kind == KIND_UNUSED) odd_sent++;
      else adds_sent++;
      if (!node_used[a] && (kind == KIND_ROOT || (kind == KIND_CHILD && node_used[b]))) begin
         node_used[a] = 1'b1;
         members      = {members, a};
         last_node    = a;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int  r;
      int  n;
      int  p;
      int  a;
      int  b;
      bit  room;
      r    = $urandom_range(99);
      room = members.size() < 900;
      if (r < 2 && room && members.size() > 0) begin
         // long chain hanging off a random node, for deep lifts
         p = members[$urandom_range(members.size() - 1)];
         repeat ($urandom_range(40, 10)) begin
            n = free_node();
            send_beat(KIND_CHILD, n, p);
            p = n;
         end
      end else if (r < 6 && room) begin
         send_beat(KIND_ROOT, free_node(), $urandom_range(1023));
      end else if (r < 42 && room && members.size() > 0) begin
         n = free_node();
         if ($urandom_range(99) < 60 && last_node >= 0) p = last_node;
         else p = members[$urandom_range(members.size() - 1)];
         send_beat(KIND_CHILD, n, p);
      end else if (r < 86 && members.size() > 0) begin
         a = members[$urandom_range(members.size() - 1)];
         b = ($urandom_range(9) == 0) ? a : members[$urandom_range(members.size() - 1)];
         send_beat(KIND_QUERY, a, b);
      end else begin
         send_beat(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle = 29;
      recv_idle = 66;

      send_beat(KIND_QUERY,  0,    1023);   // empty forest
      send_beat(KIND_CHILD,  5,    3);      // parent missing
      send_beat(KIND_ROOT,   0,    0);
      send_beat(KIND_ROOT,   0,    1023);   // added twice
      send_beat(KIND_CHILD,  0,    1023);   // present node wins over missing parent
      send_beat(KIND_CHILD,  7,    7);      // own parent
      send_beat(KIND_ROOT,   1023, 1023);
      send_beat(KIND_CHILD,  1,    0);
      send_beat(KIND_CHILD,  2,    1);
      send_beat(KIND_CHILD,  3,    2);
      send_beat(KIND_CHILD,  4,    1);
      send_beat(KIND_CHILD,  1022, 1023);
      send_beat(KIND_QUERY,  0,    0);
      send_beat(KIND_QUERY,  3,    4);
      send_beat(KIND_QUERY,  4,    3);
      send_beat(KIND_QUERY,  3,    0);
      send_beat(KIND_QUERY,  1022, 3);      // different trees
      send_beat(KIND_QUERY,  1023, 1023);
      send_beat(KIND_QUERY,  2,    9);      // second node missing
      send_beat(KIND_UNUSED, 1023, 1023);
      send_beat(KIND_UNUSED, 0,    0);
      send_beat(KIND_CHILD,  8,    9);

      while (beats_sent < 400) random_item();
      drain();

      send_idle = 66;
      recv_idle = 29;
      while (beats_sent < 780) random_item();
      drain();

      send_idle = 0;
      recv_idle = 0;
      while (beats_sent < 1172) random_item();
      drain();
      repeat (100) @(posedge clock);

      $display("covered %0d add beats, %0d queries and %0d unused-kind beats",
               adds_sent, asks_sent, odd_sent);
      $display("forest grew to %0d nodes; %0d responses checked", members.size(),
               checked_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/lca_pkg.sv
design/lca_node_store.sv
design/lca_jump_store.sv
design/lowest_common_ancestor_engine.sv
tb/sv/lca_answer_checker.sv
tb/sv/lowest_common_ancestor_engine_test.sv
